@@ src/assert_macros.svh @@
// Assertion macros shared by the box suppression RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

// Condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");

`endif

@@ src/gbos_pkg.sv @@
// Shared constants and types of the box suppression block
`default_nettype none
package gbos_pkg;
  localparam int MAX_BOXES   = 64;
  localparam int IDX_W       = $clog2(MAX_BOXES);
  localparam int CNT_W       = $clog2(MAX_BOXES + 1);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam logic [15:0] THR_RESET = 16'd26214;

  typedef struct packed {
    logic [15:0] cost;
    logic [11:0] h;
    logic [11:0] w;
    logic [11:0] y;
    logic [11:0] x;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    box_t box;
    logic final_box;
  } box_req_t;
endpackage
`default_nettype wire

@@ src/greedy_box_overlap_suppression_core.sv @@
// Top level of the greedy box overlap suppression block
//
// Boxes are requested on the in_ ports: a request is taken at a clock edge
// with start high and busy low. Requests pass through a two-entry queue into
// a 64-entry box store. A request with in_final_box set closes the set and
// starts suppression, during which busy rises once the queue fills.
// Suppression visits each surviving box i and scans the other surviving
// boxes j through the single store read port, skipping i itself and
// removed entries; each compared pair is read, multiplied, scaled by the
// threshold and compared.
// Survivors then leave in load order, each on the out_ ports for exactly one
// cycle with out_valid high; out_last_kept marks the final one and
// out_overflowed reports boxes dropped beyond 64. The receiver cannot stall
// the results. The user must write the threshold through cfg_valid/cfg_ready
// only while idle; the block does not enforce it. Synchronous reset clears
// the set, the queue and restores the threshold to 26214.
`default_nettype none
module greedy_box_overlap_suppression_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] in_box_x,
  input  wire logic [11:0] in_box_y,
  input  wire logic [11:0] in_box_width,
  input  wire logic [11:0] in_box_height,
  input  wire logic [15:0] in_box_cost,
  input  wire logic        in_final_box,
  output logic             out_valid,
  output logic [11:0]      out_kept_x,
  output logic [11:0]      out_kept_y,
  output logic [11:0]      out_kept_width,
  output logic [11:0]      out_kept_height,
  output logic [15:0]      out_kept_cost,
  output logic             out_last_kept,
  output logic             out_overflowed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_overlap_threshold
);
  gbos_pkg::box_req_t in_req, q_req;
  gbos_pkg::box_t     out_box;
  logic               q_valid, q_pop;
  logic [15:0]        thr;

  assign in_req.box.x     = in_box_x;
  assign in_req.box.y     = in_box_y;
  assign in_req.box.w     = in_box_width;
  assign in_req.box.h     = in_box_height;
  assign in_req.box.cost  = in_box_cost;
  assign in_req.final_box = in_final_box;

  gbos_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_req                (in_req),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_overlap_threshold (cfg_overlap_threshold),
    .thr                   (thr),
    .q_valid               (q_valid),
    .q_req                 (q_req),
    .q_pop                 (q_pop)
  );

  gbos_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_box   (out_box),
    .out_last  (out_last_kept),
    .out_ovf   (out_overflowed)
  );

  assign out_kept_x      = out_box.x;
  assign out_kept_y      = out_box.y;
  assign out_kept_width  = out_box.w;
  assign out_kept_height = out_box.h;
  assign out_kept_cost   = out_box.cost;
endmodule
`default_nettype wire

@@ src/gbos_ram.sv @@
// Generic single write port, single registered read port RAM
`default_nettype none
module gbos_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ src/gbos_front.sv @@
// Request intake: command handshake, threshold register and short request queue
`default_nettype none
`include "assert_macros.svh"
module gbos_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire gbos_pkg::box_req_t in_req,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_overlap_threshold,
  output logic [15:0]            thr,
  output logic                   q_valid,
  output gbos_pkg::box_req_t     q_req,
  input  wire logic              q_pop
);
  gbos_pkg::box_req_t                 q_mem_r [gbos_pkg::Q_DEPTH];
  logic [gbos_pkg::Q_PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [gbos_pkg::Q_CNT_W-1:0]       q_cnt_r;
  logic [15:0]                        thr_r;
  logic                               push, pop;

  assign busy      = (q_cnt_r == gbos_pkg::Q_CNT_W'(gbos_pkg::Q_DEPTH));
  assign push      = start && !busy;
  assign pop       = q_pop && (q_cnt_r != '0);
  assign q_valid   = (q_cnt_r != '0);
  assign q_req     = q_mem_r[rd_ptr_r];
  assign cfg_ready = 1'b1;
  assign thr       = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      thr_r    <= gbos_pkg::THR_RESET;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_overlap_threshold;
      end
      if (push) begin
        q_mem_r[wr_ptr_r] <= in_req;
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 1'b1;
        2'b01:   q_cnt_r <= q_cnt_r - 1'b1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  `ASSERT_NEVER(a_q_overrun, clk, rst_n, q_cnt_r > gbos_pkg::Q_CNT_W'(gbos_pkg::Q_DEPTH))
  `ASSERT_CLK(a_q_count, clk, rst_n, (push && !pop) |=> (q_cnt_r == $past(q_cnt_r) + 1'b1))
endmodule
`default_nettype wire

@@ src/gbos_back.sv @@
// Execution: box store, greedy pairwise suppression and survivor output
`default_nettype none
`include "assert_macros.svh"
module gbos_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [15:0]        thr,
  input  wire logic               q_valid,
  input  wire gbos_pkg::box_req_t q_req,
  output logic                    q_pop,
  output logic                    out_valid,
  output gbos_pkg::box_t          out_box,
  output logic                    out_last,
  output logic                    out_ovf
);
  typedef enum logic [3:0] {
    ST_LOAD, ST_I_CHK, ST_I_WAIT, ST_J_CHK, ST_J_WAIT,
    ST_J_MUL, ST_J_THR, ST_J_CMP, ST_E_CHK, ST_E_WAIT
  } state_t;

  state_t                          state_r;
  logic [gbos_pkg::CNT_W-1:0]      cnt_r, i_r, j_r, k_r;
  logic [gbos_pkg::MAX_BOXES-1:0]  removed_r;
  logic                            ovf_r, have_r;
  gbos_pkg::box_t                  box_i_r, box_j_r, pend_r, rd_box;
  logic [23:0]                     inter_r;
  logic [24:0]                     asum_r;
  logic [40:0]                     prod_r;
  logic                            out_valid_r, out_last_r, out_ovf_r;
  gbos_pkg::box_t                  out_box_r;
  logic [gbos_pkg::BOX_W-1:0]      rd_data;
  logic [gbos_pkg::IDX_W-1:0]      rd_addr;
  logic                            wr_en;
  logic [12:0]                     ix0, ix1, jx0, jx1, iy0, iy1, jy0, jy1;
  logic [12:0]                     lo_x, hi_x, lo_y, hi_y, sp_x, sp_y;

  assign rd_box = gbos_pkg::box_t'(rd_data);
  assign q_pop  = (state_r == ST_LOAD);
  assign wr_en  = q_pop && q_valid && (cnt_r < gbos_pkg::CNT_W'(gbos_pkg::MAX_BOXES));

  always_comb begin
    unique case (state_r)
      ST_J_CHK: rd_addr = j_r[gbos_pkg::IDX_W-1:0];
      ST_E_CHK: rd_addr = k_r[gbos_pkg::IDX_W-1:0];
      default:  rd_addr = i_r[gbos_pkg::IDX_W-1:0];
    endcase
  end

  gbos_ram #(.WIDTH(gbos_pkg::BOX_W), .DEPTH(gbos_pkg::MAX_BOXES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[gbos_pkg::IDX_W-1:0]),
    .wr_data (q_req.box),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // per-axis overlap, edges widened so the right edge cannot wrap
  always_comb begin
    ix0  = {1'b0, box_i_r.x};
    ix1  = ix0 + {1'b0, box_i_r.w};
    jx0  = {1'b0, box_j_r.x};
    jx1  = jx0 + {1'b0, box_j_r.w};
    iy0  = {1'b0, box_i_r.y};
    iy1  = iy0 + {1'b0, box_i_r.h};
    jy0  = {1'b0, box_j_r.y};
    jy1  = jy0 + {1'b0, box_j_r.h};
    lo_x = (ix0 > jx0) ? ix0 : jx0;
    hi_x = (ix1 < jx1) ? ix1 : jx1;
    lo_y = (iy0 > jy0) ? iy0 : jy0;
    hi_y = (iy1 < jy1) ? iy1 : jy1;
    sp_x = (hi_x > lo_x) ? hi_x - lo_x : '0;
    sp_y = (hi_y > lo_y) ? hi_y - lo_y : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      removed_r   <= '0;
      ovf_r       <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: begin
          if (q_valid) begin
            if (wr_en) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (q_req.final_box) begin
              i_r     <= '0;
              state_r <= ST_I_CHK;
            end
          end
        end
        ST_I_CHK: begin
          if (i_r == cnt_r) begin
            k_r     <= '0;
            have_r  <= 1'b0;
            state_r <= ST_E_CHK;
          end else if (removed_r[i_r[gbos_pkg::IDX_W-1:0]]) begin
            i_r <= i_r + 1'b1;
          end else begin
            state_r <= ST_I_WAIT;
          end
        end
        ST_I_WAIT: begin
          box_i_r <= rd_box;
          j_r     <= '0;
          state_r <= ST_J_CHK;
        end
        ST_J_CHK: begin
          if (j_r == cnt_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_I_CHK;
          end else if (j_r == i_r || removed_r[j_r[gbos_pkg::IDX_W-1:0]]) begin
            j_r <= j_r + 1'b1;
          end else begin
            state_r <= ST_J_WAIT;
          end
        end
        ST_J_WAIT: begin
          box_j_r <= rd_box;
          state_r <= ST_J_MUL;
        end
        ST_J_MUL: begin
          inter_r <= sp_x[11:0] * sp_y[11:0];
          asum_r  <= 25'({12'h000, box_i_r.w} * {12'h000, box_i_r.h})
                   + 25'({12'h000, box_j_r.w} * {12'h000, box_j_r.h});
          state_r <= ST_J_THR;
        end
        ST_J_THR: begin
          prod_r  <= thr * (asum_r - 25'(inter_r));
          state_r <= ST_J_CMP;
        end
        ST_J_CMP: begin
          if (41'({inter_r, 16'h0000}) > prod_r) begin
            if (box_i_r.cost < box_j_r.cost) begin
              removed_r[j_r[gbos_pkg::IDX_W-1:0]] <= 1'b1;
              j_r     <= j_r + 1'b1;
              state_r <= ST_J_CHK;
            end else begin
              // scanning box loses: drop it and end its scan
              removed_r[i_r[gbos_pkg::IDX_W-1:0]] <= 1'b1;
              i_r     <= i_r + 1'b1;
              state_r <= ST_I_CHK;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_J_CHK;
          end
        end
        ST_E_CHK: begin
          if (k_r == cnt_r) begin
            // flush the held survivor as the final one and clear the set
            out_valid_r <= 1'b1;
            out_box_r   <= pend_r;
            out_last_r  <= 1'b1;
            out_ovf_r   <= ovf_r;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            removed_r   <= '0;
            state_r     <= ST_LOAD;
          end else if (removed_r[k_r[gbos_pkg::IDX_W-1:0]]) begin
            k_r <= k_r + 1'b1;
          end else begin
            state_r <= ST_E_WAIT;
          end
        end
        ST_E_WAIT: begin
          if (have_r) begin
            out_valid_r <= 1'b1;
            out_box_r   <= pend_r;
            out_last_r  <= 1'b0;
            out_ovf_r   <= ovf_r;
          end
          pend_r  <= rd_box;
          have_r  <= 1'b1;
          k_r     <= k_r + 1'b1;
          state_r <= ST_E_CHK;
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_box   = out_box_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > gbos_pkg::CNT_W'(gbos_pkg::MAX_BOXES))
  `ASSERT_CLK(a_out_src, clk, rst_n, out_valid_r |-> ($past(state_r) == ST_E_CHK || $past(state_r) == ST_E_WAIT))
endmodule
`default_nettype wire
